// ===== sv/rk4_planar_vehicle_integrator_top_defines.svh =====
// assertion macros for the planar vehicle integrator
`ifndef RK4_PLANAR_VEHICLE_INTEGRATOR_TOP_DEFINES_SVH
`define RK4_PLANAR_VEHICLE_INTEGRATOR_TOP_DEFINES_SVH
`ifndef SYNTH
// antecedent in a cycle implies consequent in the same cycle
`define RPVI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// antecedent in a cycle implies consequent in the next cycle
`define RPVI_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define RPVI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define RPVI_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== sv/rpvi_pkg.sv =====
// shared types, constants and tables of the planar vehicle integrator
package rpvi_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_VX_LEFT  = 3'd0,
		REG_VX_RIGHT = 3'd1,
		REG_VY_LEFT  = 3'd2,
		REG_VY_RIGHT = 3'd3,
		REG_WZ_LEFT  = 3'd4,
		REG_WZ_RIGHT = 3'd5,
		REG_STEP     = 3'd6
	} reg_idx_t;

	localparam logic [15:0] STEP_RESET = 16'd3277;

	// angle constants in Q.30
	localparam logic signed [47:0] TWO_PI_Q30  = 48'sd6746518852;
	localparam logic signed [47:0] PI_Q30      = 48'sd3373259426;
	localparam logic signed [47:0] HALF_PI_Q30 = 48'sd1686629713;
	localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;

	// reciprocal of six scaled by 2^32, and rounding offset of the update
	localparam logic signed [31:0] RECIP6_Q32 = 32'sd715827883;
	localparam logic signed [63:0] UPD_ROUND  = 64'sd196608;

	typedef struct packed {
		logic signed [5:0][15:0] coef;
		logic        [15:0]      ts;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic signed [31:0] init_x;
		logic signed [31:0] init_y;
		logic signed [31:0] init_heading;
	} req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
	} res_t;

	// arctangent of 2^-i in Q.30
	function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
		logic signed [31:0] v;
		begin
			case (i)
				5'd0:  v = 32'sd843314856;
				5'd1:  v = 32'sd497837829;
				5'd2:  v = 32'sd263043836;
				5'd3:  v = 32'sd133525158;
				5'd4:  v = 32'sd67021686;
				5'd5:  v = 32'sd33543515;
				5'd6:  v = 32'sd16775850;
				5'd7:  v = 32'sd8388437;
				5'd8:  v = 32'sd4194282;
				5'd9:  v = 32'sd2097149;
				5'd10: v = 32'sd1048575;
				5'd11: v = 32'sd524287;
				5'd12: v = 32'sd262143;
				5'd13: v = 32'sd131071;
				5'd14: v = 32'sd65535;
				5'd15: v = 32'sd32767;
				5'd16: v = 32'sd16383;
				5'd17: v = 32'sd8191;
				5'd18: v = 32'sd4095;
				5'd19: v = 32'sd2047;
				5'd20: v = 32'sd1023;
				5'd21: v = 32'sd511;
				5'd22: v = 32'sd255;
				5'd23: v = 32'sd127;
				5'd24: v = 32'sd63;
				5'd25: v = 32'sd31;
				5'd26: v = 32'sd15;
				5'd27: v = 32'sd8;
				5'd28: v = 32'sd4;
				5'd29: v = 32'sd2;
				5'd30: v = 32'sd1;
				default: v = 32'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== sv/rpvi_mul.sv =====
// shared signed 32x32 multiplier with registered product
module rpvi_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);

	logic signed [63:0] p_q;

	// one product per cycle, available the cycle after the operands
	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

// ===== sv/rpvi_core.sv =====
// sequencer and datapath of one integration step around the shared multiplier
module rpvi_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rpvi_pkg::cfg_t  cfg,
	input  logic            start,
	input  rpvi_pkg::req_t  req,
	input  logic            out_free,
	output logic            ready,
	output rpvi_pkg::res_t  res
);

	localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam logic [4:0] COR_LAST = 5'(NSTG - 1);
	localparam logic [4:0] RED_FIRST = 5'd13;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_VEL  = 13'b0000000000010,
		ST_WZT  = 13'b0000000000100,
		ST_HOFF = 13'b0000000001000,
		ST_RED  = 13'b0000000010000,
		ST_FIX  = 13'b0000000100000,
		ST_WRAP = 13'b0000001000000,
		ST_FOLD = 13'b0000010000000,
		ST_COR  = 13'b0000100000000,
		ST_NEG  = 13'b0001000000000,
		ST_DRV  = 13'b0010000000000,
		ST_UPD  = 13'b0100000000000,
		ST_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [4:0] k_q;
	logic [1:0] stage_q;

	logic signed [15:0] lsp_q, rsp_q;
	logic signed [27:0] vx_q, vy_q, wz_q;
	logic signed [27:0] half_q;
	logic signed [28:0] full_q;
	logic signed [47:0] r_q;
	logic signed [31:0] cx_q, cy_q;
	logic               neg_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] sx_q, sy_q, t_q, q_q;
	logic signed [31:0] px_q, py_q, ph_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] p;

	rpvi_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p   (p)
	);

	// multiplier operand selection
	logic signed [31:0] ts_s;
	logic signed [31:0] sh_s;
	logic signed [15:0] vel_spd;
	logic signed [15:0] vel_coef;

	assign ts_s = 32'({16'b0, cfg.ts});
	assign sh_s = (32'(wz_q) <<< 2) + (32'(wz_q) <<< 1);
	assign vel_spd = k_q[0] ? rsp_q : lsp_q;

	always_comb begin
		vel_coef = 16'sd0;
		case (k_q[2:0])
			3'd0: vel_coef = cfg.coef[0];
			3'd1: vel_coef = cfg.coef[1];
			3'd2: vel_coef = cfg.coef[2];
			3'd3: vel_coef = cfg.coef[3];
			3'd4: vel_coef = cfg.coef[4];
			3'd5: vel_coef = cfg.coef[5];
			default: vel_coef = 16'sd0;
		endcase
	end

	always_comb begin
		ma = 32'sd0;
		mb = 32'sd0;
		case (state_q)
			ST_VEL: begin
				ma = 32'(vel_spd);
				mb = 32'(vel_coef);
			end
			ST_WZT: begin
				ma = 32'(wz_q);
				mb = ts_s;
			end
			ST_DRV: begin
				case (k_q[2:0])
					3'd0: begin ma = 32'(vx_q); mb = cx_q; end
					3'd1: begin ma = 32'(vy_q); mb = cy_q; end
					3'd2: begin ma = 32'(vx_q); mb = cy_q; end
					3'd3: begin ma = 32'(vy_q); mb = cx_q; end
					default: begin ma = 32'sd0; mb = 32'sd0; end
				endcase
			end
			ST_UPD: begin
				if (k_q[2:0] == 3'd0) begin
					mb = ts_s;
					case (stage_q)
						2'd0: ma = sx_q;
						2'd1: ma = sy_q;
						default: ma = sh_s;
					endcase
				end else if (k_q[2:0] == 3'd2) begin
					ma = t_q;
					mb = rpvi_pkg::RECIP6_Q32;
				end
			end
			default: begin
				ma = 32'sd0;
				mb = 32'sd0;
			end
		endcase
	end

	// heading of the next evaluation and its scaled angle
	logic [1:0]         stage_n;
	logic signed [28:0] hoff;
	logic signed [32:0] h_next;
	logic signed [47:0] r_init;

	assign stage_n = (state_q == ST_HOFF) ? 2'd0 : stage_q + 2'd1;

	always_comb begin
		case (stage_n)
			2'd0: hoff = 29'sd0;
			2'd1: hoff = 29'(half_q);
			default: hoff = full_q;
		endcase
	end

	assign h_next = 33'(ph_q) + 33'(hoff);
	assign r_init = 48'(h_next) <<< 14;

	// range reduction step
	logic signed [47:0] red_d;
	assign red_d = rpvi_pkg::TWO_PI_Q30 <<< k_q[3:0];

	// cordic micro-rotation
	logic signed [31:0] cor_dx, cor_dy;
	logic signed [47:0] cor_at;
	assign cor_dx = cy_q >>> k_q;
	assign cor_dy = cx_q >>> k_q;
	assign cor_at = 48'(rpvi_pkg::atan_q30(k_q));

	// rounded products of the velocity and derivative sums
	logic signed [63:0] vel_sum, dx_sum, dy_sum;
	logic signed [31:0] dx_v, dy_v, dx_w, dy_w;
	assign vel_sum = (acc_q + p + 64'sd32) >>> 6;
	assign dx_sum  = (acc_q - p + 64'sd536870912) >>> 30;
	assign dy_sum  = (acc_q + p + 64'sd536870912) >>> 30;
	assign dx_v = dx_sum[31:0];
	assign dy_v = dy_sum[31:0];
	assign dx_w = (stage_q == 2'd1) ? (dx_v <<< 2) : dx_v;
	assign dy_w = (stage_q == 2'd1) ? (dy_v <<< 2) : dy_v;

	// pose update: round, divide by six, saturate
	logic signed [63:0] t_sum;
	logic signed [31:0] rem;
	logic signed [31:0] pose_old;
	logic signed [33:0] pose_sum;
	logic signed [31:0] pose_new;

	assign t_sum = (p + rpvi_pkg::UPD_ROUND) >>> 16;
	assign rem = t_q - (q_q <<< 2) - (q_q <<< 1);

	always_comb begin
		case (stage_q)
			2'd0: pose_old = px_q;
			2'd1: pose_old = py_q;
			default: pose_old = ph_q;
		endcase
	end

	assign pose_sum = 34'(pose_old) + 34'(q_q);

	always_comb begin
		if (pose_sum > 34'sd2147483647) begin
			pose_new = 32'sh7fffffff;
		end else if (pose_sum < -34'sd2147483648) begin
			pose_new = 32'sh80000000;
		end else begin
			pose_new = pose_sum[31:0];
		end
	end

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= 5'd0;
			stage_q <= 2'd0;
			px_q    <= 32'sd0;
			py_q    <= 32'sd0;
			ph_q    <= 32'sd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.load) begin
							px_q    <= req.init_x;
							py_q    <= req.init_y;
							ph_q    <= req.init_heading;
							state_q <= ST_OUT;
						end else begin
							k_q     <= 5'd0;
							state_q <= ST_VEL;
						end
					end
				end
				ST_VEL: begin
					if (k_q == 5'd6) begin
						state_q <= ST_WZT;
					end
					k_q <= k_q + 5'd1;
				end
				ST_WZT: begin
					state_q <= ST_HOFF;
				end
				ST_HOFF: begin
					stage_q <= 2'd0;
					k_q     <= RED_FIRST;
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (k_q == 5'd0) begin
						state_q <= ST_FIX;
					end else begin
						k_q <= k_q - 5'd1;
					end
				end
				ST_FIX: begin
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					k_q     <= 5'd0;
					state_q <= ST_COR;
				end
				ST_COR: begin
					if (k_q == COR_LAST) begin
						state_q <= ST_NEG;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				ST_NEG: begin
					k_q     <= 5'd0;
					state_q <= ST_DRV;
				end
				ST_DRV: begin
					if (k_q == 5'd4) begin
						if (stage_q == 2'd2) begin
							stage_q <= 2'd0;
							k_q     <= 5'd0;
							state_q <= ST_UPD;
						end else begin
							stage_q <= stage_n;
							k_q     <= RED_FIRST;
							state_q <= ST_RED;
						end
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				ST_UPD: begin
					if (k_q == 5'd5) begin
						case (stage_q)
							2'd0: px_q <= pose_new;
							2'd1: py_q <= pose_new;
							default: ph_q <= pose_new;
						endcase
						k_q <= 5'd0;
						if (stage_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							stage_q <= stage_q + 2'd1;
						end
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lsp_q <= req.left_speed;
				rsp_q <= req.right_speed;
			end
			ST_VEL: begin
				if (k_q[0]) begin
					acc_q <= p;
				end else if (k_q == 5'd2) begin
					vx_q <= vel_sum[27:0];
				end else if (k_q == 5'd4) begin
					vy_q <= vel_sum[27:0];
				end else if (k_q == 5'd6) begin
					wz_q <= vel_sum[27:0];
				end
			end
			ST_HOFF: begin
				half_q <= 28'((p + 64'sd65536) >>> 17);
				full_q <= 29'((p + 64'sd32768) >>> 16);
				sx_q   <= 32'sd0;
				sy_q   <= 32'sd0;
				r_q    <= r_init;
			end
			ST_RED: begin
				if (r_q >= red_d) begin
					r_q <= r_q - red_d;
				end else if (r_q < 48'sd0) begin
					r_q <= r_q + red_d;
				end
			end
			ST_FIX: begin
				if (r_q < 48'sd0) begin
					r_q <= r_q + rpvi_pkg::TWO_PI_Q30;
				end
			end
			ST_WRAP: begin
				if (r_q > rpvi_pkg::PI_Q30) begin
					r_q <= r_q - rpvi_pkg::TWO_PI_Q30;
				end
			end
			ST_FOLD: begin
				cx_q <= rpvi_pkg::CORDIC_K_Q30;
				cy_q <= 32'sd0;
				if (r_q > rpvi_pkg::HALF_PI_Q30) begin
					r_q   <= r_q - rpvi_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else if (r_q < -rpvi_pkg::HALF_PI_Q30) begin
					r_q   <= r_q + rpvi_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else begin
					neg_q <= 1'b0;
				end
			end
			ST_COR: begin
				if (r_q >= 48'sd0) begin
					cx_q <= cx_q - cor_dx;
					cy_q <= cy_q + cor_dy;
					r_q  <= r_q - cor_at;
				end else begin
					cx_q <= cx_q + cor_dx;
					cy_q <= cy_q - cor_dy;
					r_q  <= r_q + cor_at;
				end
			end
			ST_NEG: begin
				if (neg_q) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
			end
			ST_DRV: begin
				if (k_q == 5'd1 || k_q == 5'd3) begin
					acc_q <= p;
				end else if (k_q == 5'd2) begin
					sx_q <= sx_q + dx_w;
				end else if (k_q == 5'd4) begin
					sy_q <= sy_q + dy_w;
					r_q  <= r_init;
				end
			end
			ST_UPD: begin
				if (k_q == 5'd1) begin
					t_q <= t_sum[31:0];
				end else if (k_q == 5'd3) begin
					q_q <= p[63:32];
				end else if (k_q == 5'd4) begin
					if (rem < 32'sd0) begin
						q_q <= q_q - 32'sd1;
					end else if (rem >= 32'sd6) begin
						q_q <= q_q + 32'sd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign ready       = (state_q == ST_IDLE);
	assign res.done    = (state_q == ST_OUT) && out_free;
	assign res.pos_x   = px_q;
	assign res.pos_y   = py_q;
	assign res.heading = ph_q;

endmodule

// ===== sv/rk4_planar_vehicle_integrator_top.sv =====
// top level of the planar vehicle pose integrator
//
// Input channel s_*: one item per step. s_tuser[0] selects the kind: 0 advances
// the pose by one fourth-order Runge-Kutta step from the wheel speeds, 1 loads
// the pose from the init fields. Output channel m_*: one item per input item,
// the pose after that item. Configuration port cfg_*: gain matrix and step
// time, written one register per cycle. The user must write them only while
// the block is idle; the block itself does not enforce this. A step is run by
// the sequencer driving one shared multiplier: three heading evaluations, each
// a 14-step range reduction and one CORDIC stage per cycle, then three
// divide-by-six updates. A load copies the init fields into the pose and goes
// straight to the output state.
// s_tready is low while an item is in work and returns the cycle after its
// result moves into the output register; a result waiting there does not
// hold off the next input item. If the receiver stalls with a result still
// waiting, the next finished result waits inside the block.
// Reset clears the pose to zero, the gains to zero and the step time to 3277.
`include "rk4_planar_vehicle_integrator_top_defines.svh"

module rk4_planar_vehicle_integrator_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// left_speed, right_speed, init_x, init_y, init_heading
	input  logic [127:0] s_tdata,
	// req_type
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, heading
	output logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	rpvi_pkg::cfg_t cfg_q;
	rpvi_pkg::req_t req;
	rpvi_pkg::res_t res;
	logic           core_ready;
	logic           out_free;
	logic           m_tvalid_q;
	logic [95:0]    m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef <= '0;
			cfg_q.ts   <= rpvi_pkg::STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpvi_pkg::REG_VX_LEFT:  cfg_q.coef[0] <= cfg_data;
				rpvi_pkg::REG_VX_RIGHT: cfg_q.coef[1] <= cfg_data;
				rpvi_pkg::REG_VY_LEFT:  cfg_q.coef[2] <= cfg_data;
				rpvi_pkg::REG_VY_RIGHT: cfg_q.coef[3] <= cfg_data;
				rpvi_pkg::REG_WZ_LEFT:  cfg_q.coef[4] <= cfg_data;
				rpvi_pkg::REG_WZ_RIGHT: cfg_q.coef[5] <= cfg_data;
				rpvi_pkg::REG_STEP:     cfg_q.ts      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// unpack the input item
	assign req.load         = s_tuser[0];
	assign req.left_speed   = s_tdata[15:0];
	assign req.right_speed  = s_tdata[31:16];
	assign req.init_x       = s_tdata[63:32];
	assign req.init_y       = s_tdata[95:64];
	assign req.init_heading = s_tdata[127:96];

	assign s_tready = core_ready;
	assign out_free = !m_tvalid_q || m_tready;

	rpvi_core #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (s_tvalid && core_ready),
		.req      (req),
		.out_free (out_free),
		.ready    (core_ready),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			m_tdata_q <= {res.heading, res.pos_y, res.pos_x};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`RPVI_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`RPVI_ASSERT_IMP(a_done_needs_room, clk, arst_n, res.done, !m_tvalid_q || m_tready)
	`RPVI_ASSERT_NXT(a_done_shows_item, clk, arst_n, res.done, m_tvalid)

endmodule

// ===== tb/sv/rk4_planar_vehicle_integrator_top_test.sv =====
// self-checking testbench of the planar vehicle pose integrator
module rk4_planar_vehicle_integrator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_STAGES = 16;
	localparam int N_RANDOM = 600;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 200;

	localparam longint PI_Q = 64'sd3373259426;
	localparam longint TWO_PI_Q = 64'sd6746518852;
	localparam longint HALF_PI_Q = 64'sd1686629713;
	localparam longint K_Q = 64'sd652032874;

	typedef enum logic {KIND_STEP = 1'b0, KIND_LOAD = 1'b1} kind_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] heading;
	} pose_t;

	typedef struct {
		kind_t       kind;
		logic [15:0] left;
		logic [15:0] right;
		logic [31:0] ix;
		logic [31:0] iy;
		logic [31:0] ih;
		bit          known;
		pose_t       pose;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	// model state
	logic signed [15:0] gain [6];
	logic [15:0]        dt;
	longint             px, py, ph;

	pose_t  pose_queue[$];
	int     errors = 0;
	longint cycles = 0;
	bit     rx_busy_stall;

	rk4_planar_vehicle_integrator_top #(.CORDIC_STAGES(N_STAGES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint t, q;
		t = n + d / 2;
		q = t / d;
		if (t % d < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// cordic rotation of the unit vector, with range reduction and fold
	function automatic void rotate(longint h, output longint c, output longint s);
		longint r, x, y, dx, dy;
		bit neg;
		r = (h * 16384) % TWO_PI_Q;
		neg = 0;
		x = K_Q;
		y = 0;
		if (r < 0) r = r + TWO_PI_Q;
		if (r > PI_Q) r = r - TWO_PI_Q;
		if (r > HALF_PI_Q) begin
			r = r - PI_Q;
			neg = 1;
		end else if (r < -HALF_PI_Q) begin
			r = r + PI_Q;
			neg = 1;
		end
		for (int i = 0; i < N_STAGES && i < 32; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (r >= 0) begin
				x = x - dx; y = y + dy;
				r = r - longint'(rpvi_pkg::atan_q30(i[4:0]));
			end else begin
				x = x + dx; y = y - dy;
				r = r + longint'(rpvi_pkg::atan_q30(i[4:0]));
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic void world_rate(longint h, longint vx, longint vy,
			output longint dx, output longint dy);
		longint c, s;
		rotate(h, c, s);
		dx = round_shift(vx * c - vy * s, 30);
		dy = round_shift(vx * s + vy * c, 30);
	endfunction

	// advances or loads the model pose and returns the pose after the item
	function automatic pose_t next_pose(row_t r);
		longint l, rr, ts, vx, vy, wz, hf, fl;
		longint k1x, k1y, k2x, k2y, k4x, k4y;
		pose_t p;
		if (r.kind == KIND_LOAD) begin
			px = longint'(signed'(r.ix));
			py = longint'(signed'(r.iy));
			ph = longint'(signed'(r.ih));
		end else begin
			l = longint'(signed'(r.left));
			rr = longint'(signed'(r.right));
			ts = longint'(dt);
			vx = round_shift(l * gain[0] + rr * gain[1], 6);
			vy = round_shift(l * gain[2] + rr * gain[3], 6);
			wz = round_shift(l * gain[4] + rr * gain[5], 6);
			hf = round_shift(wz * ts, 17);
			fl = round_shift(wz * ts, 16);
			world_rate(ph, vx, vy, k1x, k1y);
			world_rate(ph + hf, vx, vy, k2x, k2y);
			world_rate(ph + fl, vx, vy, k4x, k4y);
			px = clamp32(px + round_div((k1x + 4 * k2x + k4x) * ts, 6 * 65536));
			py = clamp32(py + round_div((k1y + 4 * k2y + k4y) * ts, 6 * 65536));
			ph = clamp32(ph + round_div(6 * wz * ts, 6 * 65536));
		end
		p.pos_x = px[31:0];
		p.pos_y = py[31:0];
		p.heading = ph[31:0];
		return p;
	endfunction

	// register write on the configuration port, mirrored in the model
	task automatic write_reg(rpvi_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rpvi_pkg::REG_STEP)
			dt = val;
		else
			gain[idx] = signed'(val);
	endtask

	task automatic drain();
		while (pose_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sends one item; valid stays high across back-to-back items
	task automatic send_item(row_t r, bit hold);
		pose_t want;
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {r.ih, r.iy, r.ix, r.right, r.left};
		want = next_pose(r);
		if (r.known && want != r.pose) begin
			$display("%0t table row mismatch: expected %h model %h", $time, r.pose, want);
			errors++;
		end
		pose_queue.push_back(want);
		do @(posedge clk); while (!s_tready);
		if (!hold) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic row_t random_row();
		row_t r;
		r.kind = ($urandom_range(0, 9) == 0) ? KIND_LOAD : KIND_STEP;
		r.left = 16'($urandom);
		r.right = 16'($urandom);
		r.ix = $urandom;
		r.iy = $urandom;
		r.ih = $urandom;
		if (r.kind == KIND_LOAD && $urandom_range(0, 3) != 0) begin
			r.ix = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			r.iy = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			r.ih = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		end
		r.known = 0;
		return r;
	endfunction

	// result check against the oldest expected pose
	always @(posedge clk) begin
		pose_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
			if (pose_queue.size() == 0) begin
				$display("%0t unexpected item: actual %h", $time, got);
				errors++;
			end else begin
				want = pose_queue.pop_front();
				if (got.pos_x !== want.pos_x) begin
					$display("%0t pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
					errors++;
				end
				if (got.pos_y !== want.pos_y) begin
					$display("%0t pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
					errors++;
				end
				if (got.heading !== want.heading) begin
					$display("%0t heading expected %h actual %h", $time, want.heading,
						got.heading);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern: alternating phases of mostly stalled and mostly ready
	always @(posedge clk) begin
		if ($urandom_range(0, 15) == 0)
			rx_busy_stall <= ~rx_busy_stall;
		m_tready <= rx_busy_stall ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
	end

	initial begin
		row_t tbl[$];
		row_t r;
		int burst;
		rx_busy_stall = 0;
		for (int i = 0; i < 6; i++) gain[i] = '0;
		dt = rpvi_pkg::STEP_RESET;
		px = 0; py = 0; ph = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero gains after reset: pose stays at zero
		r = '{KIND_STEP, 16'h7fff, 16'h8000, '1, '1, '1, 1'b1, '0};
		tbl.push_back(r);
		// load extremes and echo
		r = '{KIND_LOAD, 16'h1234, 16'h4321, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			1'b1, '{32'h7fffffff, 32'h80000000, 32'h7fffffff}};
		tbl.push_back(r);
		r = '{KIND_LOAD, 16'hffff, 16'h0000, 32'h80000000, 32'h7fffffff, 32'h80000000,
			1'b1, '{32'h80000000, 32'h7fffffff, 32'h80000000}};
		tbl.push_back(r);
		r = '{KIND_LOAD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1, '0};
		tbl.push_back(r);
		foreach (tbl[i]) send_item(tbl[i], 0);
		drain();
		tbl.delete();

		// typical gains, then steps at large, negative and wrapped headings
		write_reg(rpvi_pkg::REG_VX_LEFT, 16'h2000);
		write_reg(rpvi_pkg::REG_VX_RIGHT, 16'h2000);
		write_reg(rpvi_pkg::REG_VY_LEFT, 16'h0400);
		write_reg(rpvi_pkg::REG_VY_RIGHT, 16'hfc00);
		write_reg(rpvi_pkg::REG_WZ_LEFT, 16'hc000);
		write_reg(rpvi_pkg::REG_WZ_RIGHT, 16'h4000);
		write_reg(rpvi_pkg::REG_STEP, 16'd3277);
		tbl.push_back('{KIND_STEP, 16'h0100, 16'h0200, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h7fff, 16'h7fff, '1, '0, '1, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h8000, 16'h8000, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h8000, 16'h7fff, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_LOAD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h7fff0000, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h7fff, 16'h0000, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_LOAD, 16'h0, 16'h0, 32'h7fff0000, 32'h80010000, 32'h80000000,
			1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h7fff, 16'h7fff, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_LOAD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0001921f, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h0400, 16'h0400, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_LOAD, 16'h0, 16'h0, 32'h0, 32'h0, 32'hfffcdbc1, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h0400, 16'h0400, '0, '0, '0, 1'b0, '0});
		foreach (tbl[i]) send_item(tbl[i], 0);
		drain();
		tbl.delete();

		// extreme gains and full step time: saturation reached
		for (int i = 0; i < 6; i++)
			write_reg(rpvi_pkg::reg_idx_t'(i), (i % 2) ? 16'h7fff : 16'h8000);
		write_reg(rpvi_pkg::REG_STEP, 16'hffff);
		tbl.push_back('{KIND_LOAD, 16'h0, 16'h0, 32'h7ff00000, 32'h80100000, 32'h7ff00000,
			1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h8000, 16'h7fff, '0, '0, '0, 1'b0, '0});
		tbl.push_back('{KIND_STEP, 16'h8000, 16'h7fff, '0, '0, '0, 1'b0, '0});
		foreach (tbl[i]) send_item(tbl[i], 0);
		drain();
		tbl.delete();

		// zero step time: pose is repeated
		write_reg(rpvi_pkg::REG_STEP, 16'h0000);
		tbl.push_back('{KIND_LOAD, 16'h0, 16'h0, 32'h00012345, 32'hfffe0000, 32'h00030000, 1'b1,
			'{32'h00012345, 32'hfffe0000, 32'h00030000}});
		tbl.push_back('{KIND_STEP, 16'h7fff, 16'h8000, '0, '0, '0, 1'b1,
			'{32'h00012345, 32'hfffe0000, 32'h00030000}});
		foreach (tbl[i]) send_item(tbl[i], 0);
		drain();

		// random phases, each with fresh settings
		for (int ph_i = 0; ph_i < 6; ph_i++) begin
			for (int i = 0; i < 6; i++)
				write_reg(rpvi_pkg::reg_idx_t'(i), (ph_i == 5) ? 16'h8000 : 16'($urandom));
			write_reg(rpvi_pkg::REG_STEP,
				(ph_i == 4) ? 16'hffff : 16'($urandom_range(0, 8000)));
			for (int n = 0; n < N_RANDOM / 6; n += burst) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++)
					send_item(random_row(), b != burst - 1);
				if ($urandom_range(0, 2) != 0)
					repeat ($urandom_range(1, 200)) @(posedge clk);
			end
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/rpvi_pkg.sv
sv/rpvi_mul.sv
sv/rpvi_core.sv
sv/rk4_planar_vehicle_integrator_top.sv
tb/sv/rk4_planar_vehicle_integrator_top_test.sv
